FILE: hdl/tft_pkg.sv
// Package for the transaction field tokenizer: parse phases, token kinds,
// error codes, field lengths and the structs passed between its modules.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package tft_pkg;

  // Default width of the byte position and offset counters.
  localparam int OFFSET_W_DEF = 32;
  // Width of script lengths and input/output counts (largest legal size is 2^25).
  localparam int CNT_W        = 26;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_MASK = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_MODE  = 8'd1;

  // Parse phases.
  localparam logic [3:0] P_BUF    = 4'd0;
  localparam logic [3:0] P_HDR    = 4'd1;
  localparam logic [3:0] P_TXCNT  = 4'd2;
  localparam logic [3:0] P_VER    = 4'd3;
  localparam logic [3:0] P_INCNT  = 4'd4;
  localparam logic [3:0] P_HASH   = 4'd5;
  localparam logic [3:0] P_IDX    = 4'd6;
  localparam logic [3:0] P_INLEN  = 4'd7;
  localparam logic [3:0] P_INSCR  = 4'd8;
  localparam logic [3:0] P_SEQ    = 4'd9;
  localparam logic [3:0] P_OUTCNT = 4'd10;
  localparam logic [3:0] P_VALUE  = 4'd11;
  localparam logic [3:0] P_OUTLEN = 4'd12;
  localparam logic [3:0] P_OUTSCR = 4'd13;
  localparam logic [3:0] P_LOCK   = 4'd14;
  localparam logic [3:0] P_HALT   = 4'd15;

  // Token kinds.
  localparam logic [3:0] TK_VERSION    = 4'd0;
  localparam logic [3:0] TK_PREV_HASH  = 4'd1;
  localparam logic [3:0] TK_PREV_INDEX = 4'd2;
  localparam logic [3:0] TK_IN_SCRIPT  = 4'd3;
  localparam logic [3:0] TK_SEQUENCE   = 4'd4;
  localparam logic [3:0] TK_OUT_VALUE  = 4'd5;
  localparam logic [3:0] TK_OUT_SCRIPT = 4'd6;
  localparam logic [3:0] TK_LOCK_TIME  = 4'd7;
  localparam logic [3:0] TK_ERROR      = 4'd8;

  // Error codes carried in the value of an error token.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_ZERO_CNT  = 2'd2;
  localparam logic [1:0] ERR_TOO_BIG   = 2'd3;

  // Field lengths in bytes.
  localparam logic [CNT_W-1:0] HDR_LEN   = 26'd80;
  localparam logic [CNT_W-1:0] HASH_LEN  = 26'd32;
  localparam logic [CNT_W-1:0] VALUE_LEN = 26'd8;
  localparam logic [CNT_W-1:0] WORD_LEN  = 26'd4;

  // Compact size prefixes and the largest accepted size.
  localparam logic [7:0]  CS_PFX16  = 8'hfd;
  localparam logic [7:0]  CS_PFX32  = 8'hfe;
  localparam logic [63:0] MAX_SIZE  = 64'h0000_0000_0200_0000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] token_offset;
    logic [31:0] token_length;
    logic [63:0] field_value;
    logic [31:0] tx_number;
    logic        tx_done;
  } token_t;

  typedef struct packed {
    logic [7:0] report_mask;
    logic       block_mode;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/tft_if.sv
// Channel interfaces of the transaction field tokenizer: the raw byte stream
// and the token stream, each with valid/ready. Depends on nothing.
`default_nettype none

interface tft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface tft_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [31:0] token_offset;
  logic [31:0] token_length;
  logic [63:0] field_value;
  logic [31:0] tx_number;
  logic        tx_done;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output field_value, output tx_number,
                  output tx_done, input ready);
  modport sink   (input valid, input token_kind, input token_offset,
                  input token_length, input field_value, input tx_number,
                  input tx_done, output ready);
endinterface

`default_nettype wire

FILE: hdl/transaction_field_tokenizer_top.sv
// Top level of the transaction field tokenizer: configuration registers and
// the input register, field walker and result register. Depends on tft_pkg,
// the tft interfaces, tft_in_stage, tft_parser and tft_token_reg.
//
// The tokenizer takes one byte of serialized transaction data per cycle as
// long as the result register can take a token: every byte is handled by the
// field walker sitting between an input register and a result register, so a
// token is loaded into the result register on the step that consumes its last
// byte from the input register, and the sink takes it from there. A byte is
// held back only while a finished token waits in the result register and the
// sink is not ready. Each byte gives at most one token. The user is to write
// registers report_mask (index 0) and block_mode (index 1) only while the
// block is idle; the block does not enforce this. block_mode is sampled on
// the first byte of each buffer. There is no clearing pass after reset.
`default_nettype none

module transaction_field_tokenizer_top
  import tft_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_W_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  tft_byte_if.sink                    raw,
  tft_token_if.source                 tokens,
  input  wire logic                   write_enable,
  input  wire logic [CFG_INDEX_W-1:0] reg_index,
  input  wire logic [CFG_DATA_W-1:0]  write_data
);

  cfg_t   cfg;
  byte_t  held;
  logic   held_valid;
  logic   slot_free;
  logic   step;
  logic   tok_valid;
  token_t tok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.report_mask <= '0;
      cfg.block_mode  <= 1'b0;
    end else if (write_enable) begin
      case (reg_index)
        REG_REPORT_MASK: cfg.report_mask <= write_data;
        REG_BLOCK_MODE:  cfg.block_mode  <= write_data[0];
        default: begin
        end
      endcase
    end
  end

  // A byte is processed when one is held and the result slot can take a token.
  assign step = held_valid && slot_free;

  tft_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw),
    .take       (step),
    .held_valid (held_valid),
    .held       (held)
  );

  tft_parser #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (held),
    .cfg       (cfg),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  tft_token_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (tok_valid),
    .tok       (tok),
    .slot_free (slot_free),
    .tokens    (tokens)
  );

endmodule

`default_nettype wire

FILE: hdl/tft_in_stage.sv
// Input register of the tokenizer: holds one byte transaction until the
// parser steps on it. Depends on tft_pkg and the tft_byte_if interface.
`default_nettype none

module tft_in_stage
  import tft_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  tft_byte_if.sink  raw,
  input  wire logic take,
  output logic      held_valid,
  output byte_t     held
);

  // A new byte may enter when the register is empty or is being consumed.
  assign raw.ready = !held_valid || take;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (raw.ready) begin
      held_valid <= raw.valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (raw.ready && raw.valid) begin
      held.data_byte  <= raw.data_byte;
      held.final_byte <= raw.final_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tft_parser.sv
// Field walker of the tokenizer: parse state registers and the single-byte
// step that advances them and forms at most one token. Depends on tft_pkg.
`default_nettype none

module tft_parser
  import tft_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_W_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  byte_t     in_byte,
  input  cfg_t      cfg,
  output logic      tok_valid,
  output token_t    tok
);

  // State registers.
  logic [3:0]              phase;
  logic [CNT_W-1:0]        left;
  logic [63:0]             acc;
  logic [3:0]              vleft;
  logic [3:0]              vidx;
  logic [CNT_W-1:0]        in_rem;
  logic [CNT_W-1:0]        out_rem;
  logic [OFFSET_WIDTH-1:0] pos;
  logic [OFFSET_WIDTH-1:0] tok_start;
  logic [OFFSET_WIDTH-1:0] tx_start;
  logic [31:0]             tx_cnt;

  logic [3:0]              phase_next;
  logic [CNT_W-1:0]        left_next;
  logic [63:0]             acc_next;
  logic [3:0]              vleft_next;
  logic [3:0]              vidx_next;
  logic [CNT_W-1:0]        in_rem_next;
  logic [CNT_W-1:0]        out_rem_next;
  logic [OFFSET_WIDTH-1:0] pos_next;
  logic [OFFSET_WIDTH-1:0] tok_start_next;
  logic [OFFSET_WIDTH-1:0] tx_start_next;
  logic [31:0]             tx_cnt_next;

  // Step working values.
  logic [7:0]              b;
  logic [OFFSET_WIDTH-1:0] cur;
  logic [OFFSET_WIDTH-1:0] nxt;
  logic [3:0]              ph;
  logic [CNT_W-1:0]        lft;
  logic [OFFSET_WIDTH-1:0] ts;
  logic [OFFSET_WIDTH-1:0] txs;
  logic [63:0]             acc_e;
  logic [3:0]              vl;
  logic [3:0]              vi;
  logic [63:0]             lane_acc;
  logic                    v_done;
  logic [63:0]             v;
  logic                    ent;
  logic [3:0]              ent_ph;
  logic [CNT_W-1:0]        ent_n;
  logic                    txs_set;
  logic                    em_req;
  logic [3:0]              em_kind;
  logic [31:0]             em_len;
  logic [63:0]             em_val;
  logic                    em_done;
  logic [OFFSET_WIDTH-1:0] em_start;
  logic                    em_pass;
  logic [1:0]              err;
  logic [OFFSET_WIDTH-1:0] off_raw;
  logic [OFFSET_WIDTH-1:0] slen_raw;
  logic [OFFSET_WIDTH+31:0] off_ext;
  logic [OFFSET_WIDTH+31:0] slen_ext;
  logic                    sdone;

  assign b   = in_byte.data_byte;
  assign cur = pos;
  assign nxt = pos + OFFSET_WIDTH'(1);

  // At the start of a buffer the mode decides between header skip and version.
  always_comb begin
    if (phase == P_BUF) begin
      txs   = cur;
      ts    = cur;
      ph    = cfg.block_mode ? P_HDR : P_VER;
      lft   = cfg.block_mode ? HDR_LEN : WORD_LEN;
      acc_e = '0;
      vl    = '0;
      vi    = '0;
    end else begin
      txs   = tx_start;
      ts    = tok_start;
      ph    = phase;
      lft   = left;
      acc_e = acc;
      vl    = vleft;
      vi    = vidx;
    end
  end

  // Byte lane insert at the current little-endian position (none past eight).
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      lane_acc[8*k +: 8] = (vi == 4'(k)) ? b : acc_e[8*k +: 8];
    end
  end

  // Script length counted from the token start, modulo the position width.
  assign slen_raw = nxt - ts;
  assign slen_ext = {32'd0, slen_raw};

  // One parse step.
  always_comb begin
    phase_next     = ph;
    left_next      = lft;
    acc_next       = acc_e;
    vleft_next     = vl;
    vidx_next      = vi;
    in_rem_next    = in_rem;
    out_rem_next   = out_rem;
    pos_next       = nxt;
    tok_start_next = ts;
    tx_start_next  = txs;
    tx_cnt_next    = tx_cnt;
    v_done  = 1'b0;
    v       = lane_acc;
    ent     = 1'b0;
    ent_ph  = ph;
    ent_n   = '0;
    txs_set = 1'b0;
    em_req  = 1'b0;
    em_kind = TK_VERSION;
    em_len  = 32'd0;
    em_val  = 64'd0;
    em_done = 1'b0;
    em_start = ts;
    err     = ERR_NONE;
    sdone   = 1'b0;

    case (ph)
      P_HDR: begin
        left_next = lft - CNT_W'(1);
        if (lft == CNT_W'(1)) begin
          ent    = 1'b1;
          ent_ph = P_TXCNT;
        end
      end
      P_TXCNT, P_INCNT, P_OUTCNT, P_INLEN, P_OUTLEN: begin
        // Compact size decode.
        if (vl == 4'd0) begin
          if (b < CS_PFX16) begin
            v_done   = 1'b1;
            v        = {56'd0, b};
            acc_next = {56'd0, b};
          end else begin
            vleft_next = (b == CS_PFX16) ? 4'd2 : ((b == CS_PFX32) ? 4'd4 : 4'd8);
            acc_next   = '0;
            vidx_next  = '0;
          end
        end else begin
          acc_next   = lane_acc;
          vidx_next  = (vi == 4'd8) ? vi : vi + 4'd1;
          vleft_next = vl - 4'd1;
          v_done     = (vl == 4'd1);
          v          = lane_acc;
        end
        if (v_done) begin
          if (v > MAX_SIZE) begin
            err = ERR_TOO_BIG;
          end else if (ph == P_TXCNT) begin
            ent     = 1'b1;
            ent_ph  = P_VER;
            ent_n   = WORD_LEN;
            txs_set = 1'b1;
          end else if (ph == P_INCNT || ph == P_OUTCNT) begin
            if (v == 64'd0) begin
              err = ERR_ZERO_CNT;
            end else if (ph == P_INCNT) begin
              in_rem_next = v[CNT_W-1:0];
              ent         = 1'b1;
              ent_ph      = P_HASH;
              ent_n       = HASH_LEN;
            end else begin
              out_rem_next = v[CNT_W-1:0];
              ent          = 1'b1;
              ent_ph       = P_VALUE;
              ent_n        = VALUE_LEN;
            end
          end else if (v == 64'd0) begin
            // Empty script: zero-length token just past the length prefix.
            em_req   = 1'b1;
            em_kind  = (ph == P_INLEN) ? TK_IN_SCRIPT : TK_OUT_SCRIPT;
            em_start = nxt;
            sdone    = 1'b1;
          end else begin
            ent    = 1'b1;
            ent_ph = (ph == P_INLEN) ? P_INSCR : P_OUTSCR;
            ent_n  = v[CNT_W-1:0];
          end
        end
      end
      P_INSCR, P_OUTSCR: begin
        left_next = lft - CNT_W'(1);
        if (lft == CNT_W'(1)) begin
          em_req  = 1'b1;
          em_kind = (ph == P_INSCR) ? TK_IN_SCRIPT : TK_OUT_SCRIPT;
          em_len  = slen_ext[31:0];
          sdone   = 1'b1;
        end
      end
      P_VER, P_HASH, P_IDX, P_SEQ, P_VALUE, P_LOCK: begin
        acc_next  = lane_acc;
        vidx_next = (vi == 4'd8) ? vi : vi + 4'd1;
        left_next = lft - CNT_W'(1);
        if (lft == CNT_W'(1)) begin
          em_req = 1'b1;
          em_val = lane_acc;
          ent    = 1'b1;
          case (ph)
            P_VER: begin
              em_kind = TK_VERSION;
              em_len  = 32'd4;
              ent_ph  = P_INCNT;
            end
            P_HASH: begin
              em_kind = TK_PREV_HASH;
              em_len  = 32'd32;
              em_val  = 64'd0;
              ent_ph  = P_IDX;
              ent_n   = WORD_LEN;
            end
            P_IDX: begin
              em_kind = TK_PREV_INDEX;
              em_len  = 32'd4;
              ent_ph  = P_INLEN;
            end
            P_SEQ: begin
              em_kind     = TK_SEQUENCE;
              em_len      = 32'd4;
              in_rem_next = in_rem - CNT_W'(1);
              if (in_rem == CNT_W'(1)) begin
                ent_ph = P_OUTCNT;
              end else begin
                ent_ph = P_HASH;
                ent_n  = HASH_LEN;
              end
            end
            P_VALUE: begin
              em_kind = TK_OUT_VALUE;
              em_len  = 32'd8;
              ent_ph  = P_OUTLEN;
            end
            default: begin
              // Lock time closes the transaction.
              em_kind     = TK_LOCK_TIME;
              em_len      = 32'd4;
              em_done     = 1'b1;
              tx_cnt_next = tx_cnt + 32'd1;
              ent_ph      = P_VER;
              ent_n       = WORD_LEN;
              txs_set     = 1'b1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // End of a script: sequence for an input, next value or lock time for an output.
    if (sdone) begin
      ent = 1'b1;
      if (ph == P_INLEN || ph == P_INSCR) begin
        ent_ph = P_SEQ;
        ent_n  = WORD_LEN;
      end else begin
        out_rem_next = out_rem - CNT_W'(1);
        ent_n        = (out_rem == CNT_W'(1)) ? WORD_LEN : VALUE_LEN;
        ent_ph       = (out_rem == CNT_W'(1)) ? P_LOCK : P_VALUE;
      end
    end

    // Entering a new field clears the field-local state.
    if (ent) begin
      phase_next     = ent_ph;
      left_next      = ent_n;
      tok_start_next = nxt;
      acc_next       = '0;
      vleft_next     = '0;
      vidx_next      = '0;
    end
    if (txs_set) begin
      tx_start_next = nxt;
    end

    // A buffer may only end right after a lock time or a transaction count.
    if (err == ERR_NONE && in_byte.final_byte && ph != P_HALT &&
        !(phase_next == P_VER && left_next == WORD_LEN)) begin
      err = ERR_TRUNCATED;
    end

    if (in_byte.final_byte) begin
      phase_next    = P_BUF;
      in_rem_next   = '0;
      out_rem_next  = '0;
      pos_next      = '0;
      tx_start_next = '0;
      tx_cnt_next   = '0;
    end else if (err != ERR_NONE) begin
      phase_next = P_HALT;
    end
  end

  // Token formation: errors always pass, field tokens through the mask.
  assign em_pass = (cfg.report_mask == 8'd0) || cfg.report_mask[em_kind[2:0]];
  assign off_raw = (err != ERR_NONE) ? (cur - txs) : (em_start - txs);
  assign off_ext = {32'd0, off_raw};

  always_comb begin
    tok_valid          = step && ((err != ERR_NONE) || (em_req && em_pass));
    tok.token_offset   = off_ext[31:0];
    tok.tx_number      = tx_cnt;
    if (err != ERR_NONE) begin
      tok.token_kind   = TK_ERROR;
      tok.token_length = 32'd0;
      tok.field_value  = {62'd0, err};
      tok.tx_done      = 1'b0;
    end else begin
      tok.token_kind   = em_kind;
      tok.token_length = em_len;
      tok.field_value  = em_val;
      tok.tx_done      = em_done;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_BUF;
      left     <= '0;
      vleft    <= '0;
      vidx     <= '0;
      in_rem   <= '0;
      out_rem  <= '0;
      pos      <= '0;
      tx_start <= '0;
      tx_cnt   <= '0;
    end else if (step) begin
      phase    <= phase_next;
      left     <= left_next;
      vleft    <= vleft_next;
      vidx     <= vidx_next;
      in_rem   <= in_rem_next;
      out_rem  <= out_rem_next;
      pos      <= pos_next;
      tx_start <= tx_start_next;
      tx_cnt   <= tx_cnt_next;
    end
  end

  // Accumulator and token start.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      tok_start <= '0;
    end else if (step) begin
      acc       <= acc_next;
      tok_start <= tok_start_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tft_token_reg.sv
// Result register of the tokenizer: holds one token transaction until the
// sink takes it. Depends on tft_pkg and the tft_token_if interface.
`default_nettype none

module tft_token_reg
  import tft_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load,
  input  token_t     tok,
  output logic       slot_free,
  tft_token_if.source tokens
);

  token_t held;

  // The slot frees up in the same cycle its token is taken.
  assign slot_free = !tokens.valid || tokens.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      tokens.valid <= 1'b0;
    end else if (load) begin
      tokens.valid <= 1'b1;
    end else if (tokens.ready) begin
      tokens.valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= tok;
    end
  end

  assign tokens.token_kind   = held.token_kind;
  assign tokens.token_offset = held.token_offset;
  assign tokens.token_length = held.token_length;
  assign tokens.field_value  = held.field_value;
  assign tokens.tx_number    = held.tx_number;
  assign tokens.tx_done      = held.tx_done;

endmodule

`default_nettype wire
